@@ hw/rtl/mwuf_pkg.sv @@
// Shared constants and types for the maze wall union-find block.
// Depends on nothing; every other file imports it.
package mwuf_pkg;

  localparam int GRID_SIZE     = 21;
  localparam int CELLS_PER_ROW = (GRID_SIZE + 1) / 2;
  localparam int CELL_COUNT    = CELLS_PER_ROW * CELLS_PER_ROW;
  localparam int CELL_W        = $clog2(CELL_COUNT);
  localparam int CNT_W         = $clog2(CELL_COUNT + 1);
  localparam int COORD_W       = 5;
  localparam int UPC_W         = 3;

  typedef logic [CELL_W-1:0]  cell_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  // microprogram addresses
  typedef enum logic [UPC_W-1:0] {
    ST_IDLE   = 3'd0,
    ST_A_RD   = 3'd1,
    ST_A_TEST = 3'd2,
    ST_A_HALF = 3'd3,
    ST_B_RD   = 3'd4,
    ST_B_TEST = 3'd5,
    ST_B_HALF = 3'd6,
    ST_FIN    = 3'd7
  } step_t;

  typedef enum logic [2:0] {
    C_NEXT     = 3'd0,
    C_NO_IN    = 3'd1,
    C_NOT_WALL = 3'd2,
    C_ROOT     = 3'd3,
    C_ALWAYS   = 3'd4,
    C_OUT_BUSY = 3'd5
  } cond_t;

  typedef enum logic [1:0] {
    RD_NONE  = 2'd0,
    RD_X     = 2'd1,
    RD_EFF   = 2'd2,
    RD_CELL2 = 2'd3
  } rd_t;

  typedef struct packed {
    logic  accept;
    rd_t   rd;
    logic  halve;
    logic  save_a;
    logic  finish;
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic wall;
    logic root_hit;
    logic out_busy;
  } stat_t;

endpackage

@@ hw/rtl/mwuf_if.sv @@
// Channel interfaces: candidate wall words in, carve result words out.
// Depends on mwuf_pkg.
interface mwuf_in_if import mwuf_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   restart;
  coord_t wall_row;
  coord_t wall_col;

  modport source (output valid, restart, wall_row, wall_col, input ready);
  modport sink   (input valid, restart, wall_row, wall_col, output ready);
endinterface

interface mwuf_out_if import mwuf_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   carved;
  coord_t carved_row;
  coord_t carved_col;
  coord_t first_cell_row;
  coord_t first_cell_col;
  coord_t second_cell_row;
  coord_t second_cell_col;
  logic   maze_done;

  modport source (output valid, carved, carved_row, carved_col, first_cell_row,
                  first_cell_col, second_cell_row, second_cell_col, maze_done,
                  input ready);
  modport sink   (input valid, carved, carved_row, carved_col, first_cell_row,
                  first_cell_col, second_cell_row, second_cell_col, maze_done,
                  output ready);
endinterface

@@ hw/rtl/mwuf_seq.sv @@
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on mwuf_pkg; drives mwuf_dp through ctrl_t.
module mwuf_seq import mwuf_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  stat_t st,
  output ctrl_t cw
);

  step_t upc_r, upc_nxt;
  logic  take;

  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    w = '{accept: 1'b0, rd: RD_NONE, halve: 1'b0, save_a: 1'b0, finish: 1'b0,
          cond: C_NEXT, target: ST_IDLE};
    case (s)
      ST_IDLE: begin
        w.accept = 1'b1; w.cond = C_NO_IN; w.target = ST_IDLE;
      end
      ST_A_RD: begin
        w.rd = RD_X; w.cond = C_NOT_WALL; w.target = ST_FIN;
      end
      ST_A_TEST: begin
        w.rd = RD_EFF; w.cond = C_ROOT; w.target = ST_B_RD;
      end
      ST_A_HALF: begin
        w.halve = 1'b1; w.rd = RD_EFF; w.cond = C_ALWAYS; w.target = ST_A_TEST;
      end
      ST_B_RD: begin
        w.save_a = 1'b1; w.rd = RD_CELL2;
      end
      ST_B_TEST: begin
        w.rd = RD_EFF; w.cond = C_ROOT; w.target = ST_FIN;
      end
      ST_B_HALF: begin
        w.halve = 1'b1; w.rd = RD_EFF; w.cond = C_ALWAYS; w.target = ST_B_TEST;
      end
      ST_FIN: begin
        // falls through to ST_IDLE by wraparound
        w.finish = 1'b1; w.cond = C_OUT_BUSY; w.target = ST_FIN;
      end
      default: begin
        w.cond = C_ALWAYS; w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

  assign cw = ucode(upc_r);

  always_comb begin
    case (cw.cond)
      C_NEXT:     take = 1'b0;
      C_NO_IN:    take = !st.in_valid;
      C_NOT_WALL: take = !st.wall;
      C_ROOT:     take = st.root_hit;
      C_ALWAYS:   take = 1'b1;
      C_OUT_BUSY: take = st.out_busy;
      default:    take = 1'b1;
    endcase
    upc_nxt = take ? cw.target : step_t'(upc_r + UPC_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= ST_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

@@ hw/rtl/mwuf_dp.sv @@
// Datapath: wall decode, parent memory with valid bits, root registers,
// set counter and result register. Depends on mwuf_pkg and mwuf_if.
module mwuf_dp import mwuf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  ctrl_t      cw,
  output stat_t      st,
  mwuf_in_if.sink    in_ch,
  mwuf_out_if.source out_ch
);

  function automatic cell_t cell_idx(coord_t r, coord_t c);
    return CELL_W'(int'(r[COORD_W-1:1]) * CELLS_PER_ROW + int'(c[COORD_W-1:1]));
  endfunction

  // decode of the incoming word
  coord_t r, c, r1, c1, r2, c2;
  logic   in_grid, vwall, hwall, is_wall, accept;

  assign r      = in_ch.wall_row;
  assign c      = in_ch.wall_col;
  assign accept = cw.accept && in_ch.valid;
  assign in_ch.ready = cw.accept;

  always_comb begin
    in_grid = (int'(r) < GRID_SIZE) && (int'(c) < GRID_SIZE);
    vwall   = in_grid && r[0] && !c[0] && (int'(r) + 1 < GRID_SIZE);
    hwall   = in_grid && !r[0] && c[0] && (int'(c) + 1 < GRID_SIZE);
    is_wall = vwall || hwall;
    r1 = vwall ? r - COORD_W'(1) : r;
    r2 = vwall ? r + COORD_W'(1) : r;
    c1 = hwall ? c - COORD_W'(1) : c;
    c2 = hwall ? c + COORD_W'(1) : c;
  end

  logic   wall_r;
  coord_t row_r, col_r, r1_r, c1_r, r2_r, c2_r;
  cell_t  x_r, root_a_r, cell2_r;

  // parent memory; an entry without its valid bit is its own root
  cell_t                 mem [CELL_COUNT];
  logic [CELL_COUNT-1:0] vld_r;
  cell_t                 rdat_r, rva_r, rd_addr, wr_addr, wr_data, eff;
  logic                  rvl_r, rd_en, wr_en;

  logic carve, fin_fire, out_busy, out_valid_r;
  cnt_t cnt_r, cnt_nxt;

  assign eff      = rvl_r ? rdat_r : rva_r;
  assign carve    = wall_r && (root_a_r != x_r);
  assign out_busy = out_valid_r && !out_ch.ready;
  assign fin_fire = cw.finish && !out_busy;

  assign st = '{in_valid: in_ch.valid, wall: wall_r, root_hit: (eff == x_r),
                out_busy: out_busy};

  always_comb begin
    case (cw.rd)
      RD_X:     rd_addr = x_r;
      RD_EFF:   rd_addr = eff;
      RD_CELL2: rd_addr = cell2_r;
      default:  rd_addr = x_r;
    endcase
    rd_en = (cw.rd != RD_NONE);
    if (cw.halve) begin
      wr_en   = 1'b1;
      wr_addr = x_r;
      wr_data = eff;
    end else begin
      // union: larger root goes below the smaller one
      wr_en   = fin_fire && carve;
      wr_addr = (root_a_r > x_r) ? root_a_r : x_r;
      wr_data = (root_a_r > x_r) ? x_r : root_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdat_r <= mem[rd_addr];
      rvl_r  <= vld_r[rd_addr];
      rva_r  <= rd_addr;
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (accept && in_ch.restart) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // item registers
  always_ff @(posedge clk) begin
    if (accept) begin
      wall_r  <= is_wall;
      row_r   <= r;
      col_r   <= c;
      r1_r    <= r1;
      c1_r    <= c1;
      r2_r    <= r2;
      c2_r    <= c2;
      x_r     <= is_wall ? cell_idx(r1, c1) : '0;
      cell2_r <= is_wall ? cell_idx(r2, c2) : '0;
    end else if (cw.halve) begin
      x_r <= eff;
    end else if (cw.save_a) begin
      root_a_r <= x_r;
      x_r      <= cell2_r;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept && in_ch.restart) begin
      cnt_nxt = CNT_W'(CELL_COUNT);
    end else if (fin_fire && carve && (cnt_r != '0)) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= CNT_W'(CELL_COUNT);
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (fin_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      out_ch.carved          <= carve;
      out_ch.carved_row      <= carve ? row_r : '0;
      out_ch.carved_col      <= carve ? col_r : '0;
      out_ch.first_cell_row  <= carve ? r1_r : '0;
      out_ch.first_cell_col  <= carve ? c1_r : '0;
      out_ch.second_cell_row <= carve ? r2_r : '0;
      out_ch.second_cell_col <= carve ? c2_r : '0;
      out_ch.maze_done       <= (cnt_nxt == CNT_W'(1));
    end
  end

  assign out_ch.valid = out_valid_r;

endmodule

@@ hw/rtl/maze_wall_union_find.sv @@
// Top level of the maze wall union-find block: sequencer plus datapath.
// Depends on mwuf_pkg, mwuf_if, mwuf_seq and mwuf_dp.
//
//   channel  dir  handshake    word
//   in_ch    in   valid/ready  restart, wall_row, wall_col
//   out_ch   out  valid/ready  carved, six coordinates, maze_done
//
// One wall at a time: a non-wall position goes straight to the finish
// step; a wall walks to the root of each of its two cells with path halving;
// a hop costs two registered parent reads. The result sits in an output
// register, so a stalled out_ch holds the next wall only at its last step.
// Synchronous active-low reset; parent entries use valid bits, so reset and
// restart take effect at once with no clearing sweep.
module maze_wall_union_find import mwuf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  mwuf_in_if.sink    in_ch,
  mwuf_out_if.source out_ch
);

  ctrl_t cw;
  stat_t st;

  mwuf_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cw    (cw)
  );

  mwuf_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cw     (cw),
    .st     (st),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

@@ hw/rtl/mwuf_chk.sv @@
// Port-level checker for maze_wall_union_find, attached by bind.
// Depends on mwuf_pkg.
module mwuf_chk import mwuf_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  input logic   in_valid,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input logic   carved,
  input coord_t carved_row,
  input coord_t carved_col,
  input coord_t first_cell_row,
  input coord_t first_cell_col,
  input coord_t second_cell_row,
  input coord_t second_cell_col,
  input logic   maze_done
);

  // one wall in flight
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second wall taken while one is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(carved)
      && $stable(carved_row) && $stable(carved_col) && $stable(maze_done))
    else $error("stalled result word changed");

  a_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && carved |->
      ((carved_row == COORD_W'(first_cell_row + COORD_W'(1)))
        && (second_cell_row == COORD_W'(carved_row + COORD_W'(1)))
        && (first_cell_col == carved_col) && (second_cell_col == carved_col))
      || ((carved_col == COORD_W'(first_cell_col + COORD_W'(1)))
        && (second_cell_col == COORD_W'(carved_col + COORD_W'(1)))
        && (first_cell_row == carved_row) && (second_cell_row == carved_row)))
    else $error("carved wall does not sit between its two cells");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !carved |->
      (carved_row == '0) && (carved_col == '0) && (first_cell_row == '0)
      && (first_cell_col == '0) && (second_cell_row == '0)
      && (second_cell_col == '0))
    else $error("rejected wall reports coordinates");

endmodule

bind maze_wall_union_find mwuf_chk u_mwuf_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .carved          (out_ch.carved),
  .carved_row      (out_ch.carved_row),
  .carved_col      (out_ch.carved_col),
  .first_cell_row  (out_ch.first_cell_row),
  .first_cell_col  (out_ch.first_cell_col),
  .second_cell_row (out_ch.second_cell_row),
  .second_cell_col (out_ch.second_cell_col),
  .maze_done       (out_ch.maze_done)
);

@@ sim/mwuf_carve_checker.sv @@
// Carve checker for maze_wall_union_find: watches both channels, predicts each
// result word with its own union-find copy and compares field by field.
// Depends on mwuf_pkg and mwuf_if.
module mwuf_carve_checker import mwuf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  mwuf_in_if   in_ch,
  mwuf_out_if  out_ch,
  output int   errors,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic   carved;
    coord_t wall_row;
    coord_t wall_col;
    coord_t cell1_row;
    coord_t cell1_col;
    coord_t cell2_row;
    coord_t cell2_col;
    logic   done;
  } carve_t;

  cell_t  parent_of [CELL_COUNT];
  cnt_t   sets_left;
  carve_t carve_q [$];

  function automatic void clear_sets();
    for (int i = 0; i < CELL_COUNT; i++) parent_of[i] = cell_t'(i);
    sets_left = cnt_t'(CELL_COUNT);
  endfunction

  function automatic cell_t cell_of(int r, int c);
    return cell_t'((r / 2) * CELLS_PER_ROW + (c / 2));
  endfunction

  // root walk with path halving
  function automatic cell_t root_of(cell_t x);
    cell_t gp;
    int    hops;
    hops = 0;
    while (parent_of[x] != x && hops < CELL_COUNT) begin
      gp = parent_of[parent_of[x]];
      parent_of[x] = gp;
      x = gp;
      hops++;
    end
    return x;
  endfunction

  function automatic carve_t carve_wall(logic rs, coord_t r, coord_t c);
    carve_t res;
    int     ri, ci, r1, c1, r2, c2;
    bit     is_wall;
    cell_t  a, b;
    res = '0;
    ri = int'(r);
    ci = int'(c);
    r1 = 0; c1 = 0; r2 = 0; c2 = 0;
    is_wall = 1'b0;
    if (rs) clear_sets();
    if (ri < GRID_SIZE && ci < GRID_SIZE) begin
      if (ri % 2 == 1 && ci % 2 == 0 && ri + 1 < GRID_SIZE) begin
        r1 = ri - 1; c1 = ci; r2 = ri + 1; c2 = ci;
        is_wall = 1'b1;
      end else if (ri % 2 == 0 && ci % 2 == 1 && ci + 1 < GRID_SIZE) begin
        r1 = ri; c1 = ci - 1; r2 = ri; c2 = ci + 1;
        is_wall = 1'b1;
      end
    end
    if (is_wall) begin
      a = root_of(cell_of(r1, c1));
      b = root_of(cell_of(r2, c2));
      if (a != b) begin
        // larger root goes under the smaller one
        if (a < b) parent_of[b] = a;
        else parent_of[a] = b;
        if (sets_left > 0) sets_left--;
        res.carved    = 1'b1;
        res.wall_row  = r;
        res.wall_col  = c;
        res.cell1_row = coord_t'(r1);
        res.cell1_col = coord_t'(c1);
        res.cell2_row = coord_t'(r2);
        res.cell2_col = coord_t'(c2);
      end
    end
    res.done = (sets_left == 1);
    return res;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    carve_t want;
    if (!rst_n) begin
      clear_sets();
      carve_q.delete();
      outstanding = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (carve_q.size() == 0) begin
          $error("result word with no wall pending");
          errors++;
        end else begin
          want = carve_q.pop_front();
          check_field("carved", int'(want.carved), int'(out_ch.carved));
          check_field("carved_row", int'(want.wall_row), int'(out_ch.carved_row));
          check_field("carved_col", int'(want.wall_col), int'(out_ch.carved_col));
          check_field("first_cell_row", int'(want.cell1_row),
                      int'(out_ch.first_cell_row));
          check_field("first_cell_col", int'(want.cell1_col),
                      int'(out_ch.first_cell_col));
          check_field("second_cell_row", int'(want.cell2_row),
                      int'(out_ch.second_cell_row));
          check_field("second_cell_col", int'(want.cell2_col),
                      int'(out_ch.second_cell_col));
          check_field("maze_done", int'(want.done), int'(out_ch.maze_done));
        end
      end
      if (in_ch.valid && in_ch.ready)
        carve_q = {carve_q, carve_wall(in_ch.restart, in_ch.wall_row, in_ch.wall_col)};
      outstanding = carve_q.size();
    end
  end

endmodule

@@ sim/tb_maze_wall_union_find.sv @@
// Testbench top for maze_wall_union_find: clock, reset, wall word stimulus,
// random stalls on the result side, watchdog and verdict.
// Depends on mwuf_pkg, mwuf_if, the RTL and mwuf_carve_checker.
module tb_maze_wall_union_find;
  import mwuf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_ITEMS     = 1350;
  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_CYCLES = 80;

  typedef struct packed {
    coord_t row;
    coord_t col;
  } pos_t;

  logic clk = 1'b0;
  logic rst_n;
  bit   calm;
  int   n_err, n_open, n_sent, quiet;
  pos_t walls [$];

  mwuf_in_if  in_ch ();
  mwuf_out_if out_ch ();

  maze_wall_union_find i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  mwuf_carve_checker i_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .errors      (n_err),
    .outstanding (n_open)
  );

  always #2 clk = ~clk;

  initial out_ch.ready = 1'b0;
  always @(negedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 32);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_wall(input logic rs, input coord_t r, input coord_t c);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 32) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.restart  <= rs;
    in_ch.wall_row <= r;
    in_ch.wall_col <= c;
    do @(posedge clk); while (!in_ch.ready);
    n_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (n_open != 0) @(negedge clk);
  endtask

  task automatic shuffle_walls();
    pos_t tmp;
    int   j;
    for (int i = walls.size() - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = walls[i];
      walls[i] = walls[j];
      walls[j] = tmp;
    end
  endtask

  initial begin
    int kind, len, pass_no;
    bit rs;
    rst_n          = 1'b0;
    calm           = 1'b0;
    quiet          = 0;
    n_sent         = 0;
    in_ch.valid    = 1'b0;
    in_ch.restart  = 1'b0;
    in_ch.wall_row = '0;
    in_ch.wall_col = '0;
    for (int r = 0; r < GRID_SIZE; r++)
      for (int c = 0; c < GRID_SIZE; c++)
        if ((r % 2 == 1 && c % 2 == 0 && r + 1 < GRID_SIZE) ||
            (r % 2 == 0 && c % 2 == 1 && c + 1 < GRID_SIZE))
          walls = {walls, pos_t'({coord_t'(r), coord_t'(c)})};
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // directed: carve, same set, cell, pillar, off-grid, corners, restart
    send_wall(1'b1, 5'd1, 5'd0);
    send_wall(1'b0, 5'd1, 5'd0);
    send_wall(1'b0, 5'd0, 5'd0);
    send_wall(1'b0, 5'd1, 5'd1);
    send_wall(1'b0, 5'd20, 5'd20);
    send_wall(1'b0, 5'd21, 5'd0);
    send_wall(1'b0, 5'd0, 5'd21);
    send_wall(1'b0, 5'd31, 5'd31);
    send_wall(1'b0, 5'd31, 5'd0);
    send_wall(1'b0, 5'd0, 5'd31);
    send_wall(1'b0, 5'd19, 5'd20);
    send_wall(1'b0, 5'd20, 5'd19);
    send_wall(1'b0, 5'd0, 5'd1);
    send_wall(1'b0, 5'd2, 5'd1);
    send_wall(1'b0, 5'd1, 5'd2);
    send_wall(1'b1, 5'd31, 5'd31);
    send_wall(1'b0, 5'd1, 5'd0);
    send_wall(1'b1, 5'd1, 5'd0);
    drain();

    pass_no = 0;
    while (n_sent < N_ITEMS) begin
      kind = $urandom_range(9);
      calm = (pass_no == 1);
      if (pass_no == 1) kind = 0;
      if (kind <= 6) begin
        // full maze with stray words mixed in, then words after done
        shuffle_walls();
        foreach (walls[i]) begin
          if ($urandom_range(19) == 0)
            send_wall(1'b0, coord_t'($urandom_range(31)), coord_t'($urandom_range(31)));
          send_wall(i == 0, walls[i].row, walls[i].col);
        end
        repeat ($urandom_range(5))
          send_wall(1'b0, coord_t'($urandom_range(31)), coord_t'($urandom_range(31)));
      end else if (kind == 7) begin
        shuffle_walls();
        len = $urandom_range(1, 150);
        rs  = ($urandom_range(1) == 1);
        for (int i = 0; i < len; i++)
          send_wall(rs && i == 0, walls[i].row, walls[i].col);
      end else begin
        repeat ($urandom_range(5, 30))
          send_wall($urandom_range(15) == 0, coord_t'($urandom_range(31)),
                    coord_t'($urandom_range(31)));
      end
      if ($urandom_range(3) == 0) drain();
      pass_no++;
    end
    calm = 1'b0;

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (n_open != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (n_err == 0 && n_open == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/mwuf_pkg.sv
hw/rtl/mwuf_if.sv
hw/rtl/mwuf_seq.sv
hw/rtl/mwuf_dp.sv
hw/rtl/maze_wall_union_find.sv
hw/rtl/mwuf_chk.sv
sim/mwuf_carve_checker.sv
sim/tb_maze_wall_union_find.sv
